// ===== src/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int VALUE_W       = 32;
  localparam int PRIO_W        = 16;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [VALUE_W-1:0] item_value;
    logic [PRIO_W-1:0]  item_priority;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] head_value;
    logic [PRIO_W-1:0]  head_priority;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    logic               queue_empty;
  } res_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller and cell-array datapath.
// Each request is captured when accepted and executed in the execute state; the
// result strobe and result come from registers. A new request is accepted only
// when idle; the cell array inserts or shifts all entries at once.
// Reset: synchronous active-low reset empties the queue and returns to idle.
// The result is shown for one cycle only, since the receiver cannot stall.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t in_req,
  output logic          out_valid,
  output spq_pkg::res_t out_res
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule

// ===== src/spq_ctrl.sv =====
// Controller state machine that sequences request capture, execution and the result strobe.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output logic          out_valid,
  output spq_pkg::cmd_t cmd
);

  spq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    busy          = 1'b0;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        busy          = 1'b1;
        cmd.execute   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/spq_datapath.sv =====
// Datapath: sorted shift-register cell array, entry count and result register.
module spq_datapath #(
  parameter int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spq_pkg::cmd_t cmd,
  input  spq_pkg::req_t in_req,
  output spq_pkg::res_t out_res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::req_t                 req_r;
  logic [spq_pkg::VALUE_W-1:0]   val_r    [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    prio_r   [QUEUE_DEPTH];
  logic [spq_pkg::VALUE_W-1:0]   val_nxt  [QUEUE_DEPTH];
  logic [spq_pkg::PRIO_W-1:0]    prio_nxt [QUEUE_DEPTH];
  logic [CW-1:0]                 count_r, count_nxt;
  spq_pkg::res_t                 res_r, res_nxt;
  logic [QUEUE_DEPTH-1:0]        after;
  logic                          full, empty, do_push, do_pop;
  logic [CW+spq_pkg::COUNT_W-1:0] count_ext;

  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = (req_r.opcode == spq_pkg::OP_PUSH) && !full;
  assign do_pop  = (req_r.opcode == spq_pkg::OP_POP) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign after[i] = (CW'(i) >= count_r) || (prio_r[i] > req_r.item_priority);

    always_comb begin
      val_nxt[i]  = val_r[i];
      prio_nxt[i] = prio_r[i];
      if (do_push && after[i]) begin
        if (i == 0) begin
          val_nxt[i]  = req_r.item_value;
          prio_nxt[i] = req_r.item_priority;
        end else if (!after[(i > 0) ? i - 1 : 0]) begin
          val_nxt[i]  = req_r.item_value;
          prio_nxt[i] = req_r.item_priority;
        end else begin
          val_nxt[i]  = val_r[(i > 0) ? i - 1 : 0];
          prio_nxt[i] = prio_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_pop && (i < QUEUE_DEPTH - 1)) begin
        val_nxt[i]  = val_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        prio_nxt[i] = prio_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.execute) begin
        val_r[i]  <= val_nxt[i];
        prio_r[i] <= prio_nxt[i];
      end
    end
  end

  always_comb begin
    count_nxt             = count_r;
    res_nxt.head_value    = '0;
    res_nxt.head_priority = '0;
    res_nxt.status        = spq_pkg::STAT_OK;
    case (spq_pkg::op_t'(req_r.opcode))
      spq_pkg::OP_PUSH: begin
        if (full) begin
          res_nxt.status = spq_pkg::STAT_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
        if (empty) begin
          res_nxt.status = spq_pkg::STAT_EMPTY;
        end else begin
          res_nxt.head_value    = val_r[0];
          res_nxt.head_priority = prio_r[0];
          if (req_r.opcode == spq_pkg::OP_POP) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      spq_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    count_ext           = {{spq_pkg::COUNT_W{1'b0}}, count_nxt};
    res_nxt.entry_count = count_ext[spq_pkg::COUNT_W-1:0];
    res_nxt.queue_empty = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  assign out_res = res_r;

endmodule

// ===== src/spq_checker.sv =====
// Port-level checker for the sorted priority queue and its bind statement.
module spq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input spq_pkg::res_t out_res
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("no result two cycles after an accepted request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.queue_empty) |-> (out_res.entry_count == '0))
    else $error("empty flag set with a nonzero count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == spq_pkg::STAT_EMPTY)) |->
      (out_res.queue_empty && (out_res.head_value == '0)))
    else $error("empty error reported on a queue that holds entries");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
